// ===== src/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, widths and constants of the pen stroke point smoother.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int WINDOW_SIZE_DEF = 10;

  localparam int COORD_W   = 24;
  localparam int PRESS_W   = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int FOLLOW_W  = 9;

  // Datapath widths
  localparam int DIFF_W    = COORD_W + 1;     // sample minus kept point
  localparam int D2_W      = 2 * COORD_W + 1; // dx*dx + dy*dy
  localparam int ROOT_W    = COORD_W + 1;
  localparam int DIV_NUM_W = 29;
  localparam int DIV_DEN_W = 16;
  localparam int QUO_W     = 13;
  localparam int DIV_CNT_W = 4;

  localparam logic [PRESS_W-1:0]  PRESS_ONE  = 13'd4096;
  localparam logic [PRESS_W-1:0]  PRESS_HALF = 13'd2048;
  localparam logic [FOLLOW_W-1:0] FOLLOW_ONE = 9'd256;

  // Register reset values
  localparam logic [FOLLOW_W-1:0] FOLLOW_RST   = 9'd128;
  localparam logic [CFG_W-1:0]    MIN_DIST_RST = 16'd256;
  localparam logic [CFG_W-1:0]    DIST_LIM_RST = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLLOW     = 2'd0,
    CFG_SIMULATE   = 2'd1,
    CFG_MIN_DIST   = 2'd2,
    CFG_DIST_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [PRESS_W-1:0]        pen_pressure;
    logic                      stroke_end;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [PRESS_W-1:0]        out_pressure;
    logic                      out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    OUT_SEL_AVG   = 2'd0,
    OUT_SEL_RAW   = 2'd1,
    OUT_SEL_FLUSH = 2'd2
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     latch_in;
    logic     stroke_start;
    logic     cand_raw;
    logic     diff;
    logic     square;
    logic     sum;
    logic     cand_smooth;
    logic     sqrt_start;
    logic     pdiv_start;
    logic     press_half;
    logic     press_div;
    logic     keep;
    logic     avg_start;
    logic     fl_clear;
    logic     fl_inc;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     finish;
  } pss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_stroke;
    logic sample_end;
    logic dist_keep;
    logic simulate;
    logic half_hit;
    logic root_done;
    logic div_done;
    logic cnt_full;
    logic cnt_fill_next;
    logic fl_last;
    logic out_free;
  } pss_sts_t;

endpackage

// ===== src/pss_isqrt.sv =====
// ----------------------------------------------------------------------------
// pss_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pss_isqrt import pss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [D2_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [D2_W-1:0] v_r;
  logic [D2_W-1:0] r_r;
  logic [D2_W-1:0] bit_r;
  logic            done_r;
  logic [D2_W-1:0] trial;

  assign trial = r_r + bit_r;

  // Control: bit marker walks down two places a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= bit_r[0];
      if (start) begin
        bit_r <= D2_W'(1) << (D2_W - 1);
      end else begin
        bit_r <= bit_r >> 2;
      end
    end
  end

  // Remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= radicand;
      r_r <= '0;
    end else if (bit_r != '0) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

// ===== src/pss_div.sv =====
// ----------------------------------------------------------------------------
// pss_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module pss_div import pss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [QUO_W-1:0]     quo
);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [QUO_W-1:0]     lo_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   sub;
  logic                 ge;

  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign sub   = trial - {1'b0, den_r};

  // Control: count the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[DIV_NUM_W-1:QUO_W];
      lo_r  <= num[QUO_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== src/pss_dp.sv =====
// ----------------------------------------------------------------------------
// pss_dp
// Datapath: registers, sample arithmetic, pressure window, startup point
// buffer, square root and divider units, and the output register.
// ----------------------------------------------------------------------------
module pss_dp import pss_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_item_t             in_data,
  input  pss_cmd_t             cmd,
  output pss_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int TW = $clog2(WINDOW_SIZE * 4096 + 1);

  // Configuration
  logic [FOLLOW_W-1:0] follow_r;
  logic                simulate_r;
  logic [CFG_W-1:0]    min_dist_r;
  logic [CFG_W-1:0]    dist_lim_r;

  // Stroke state
  logic                      in_stroke_r;
  logic signed [COORD_W-1:0] kept_x_r;
  logic signed [COORD_W-1:0] kept_y_r;
  logic [TW-1:0]             total_r;
  logic [CW-1:0]             count_r;
  logic [IW-1:0]             ptr_r;
  logic [IW-1:0]             fl_idx_r;

  // Sample and candidate point
  logic signed [COORD_W-1:0] samp_x_r;
  logic signed [COORD_W-1:0] samp_y_r;
  logic [PRESS_W-1:0]        samp_p_r;
  logic                      samp_end_r;
  logic signed [COORD_W-1:0] cand_x_r;
  logic signed [COORD_W-1:0] cand_y_r;
  logic [PRESS_W-1:0]        cand_p_r;

  // Distance arithmetic
  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic [2*COORD_W-1:0]      sq_x_r;
  logic [2*COORD_W-1:0]      sq_y_r;
  logic [D2_W-1:0]           d2_r;
  logic [2*CFG_W-1:0]        md2_r;

  // Memories
  logic [PRESS_W-1:0]   win_mem [WINDOW_SIZE];
  logic [2*COORD_W-1:0] pts_mem [WINDOW_SIZE];
  logic [PRESS_W-1:0]   win_rd_r;
  logic [2*COORD_W-1:0] pts_rd_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Combinational helpers
  logic [FOLLOW_W-1:0]        follow_eff;
  logic signed [FOLLOW_W:0]   follow_s;
  logic signed [DIFF_W-1:0]   diff_x;
  logic signed [DIFF_W-1:0]   diff_y;
  logic signed [DIFF_W+FOLLOW_W:0] prod_x;
  logic signed [DIFF_W+FOLLOW_W:0] prod_y;
  logic signed [DIFF_W+FOLLOW_W:0] rnd_x;
  logic signed [DIFF_W+FOLLOW_W:0] rnd_y;
  logic signed [2*DIFF_W-1:0] sqr_x;
  logic signed [2*DIFF_W-1:0] sqr_y;
  logic [CFG_W-1:0]           lim_eff;
  logic [PRESS_W-1:0]         in_p_clamped;
  logic [ROOT_W-1:0]          root;
  logic                       root_done;
  logic                       div_start;
  logic [DIV_NUM_W-1:0]       div_num;
  logic [DIV_DEN_W-1:0]       div_den;
  logic [QUO_W-1:0]           quo;
  logic                       div_done;
  logic                       out_free;

  assign follow_eff   = (follow_r > FOLLOW_ONE) ? FOLLOW_ONE : follow_r;
  assign follow_s     = $signed({1'b0, follow_eff});
  assign diff_x       = {samp_x_r[COORD_W-1], samp_x_r} - {kept_x_r[COORD_W-1], kept_x_r};
  assign diff_y       = {samp_y_r[COORD_W-1], samp_y_r} - {kept_y_r[COORD_W-1], kept_y_r};
  assign prod_x       = diff_x * follow_s;
  assign prod_y       = diff_y * follow_s;
  assign rnd_x        = prod_x + 128;
  assign rnd_y        = prod_y + 128;
  assign sqr_x        = dx_r * dx_r;
  assign sqr_y        = dy_r * dy_r;
  assign lim_eff      = (dist_lim_r == '0) ? CFG_W'(1) : dist_lim_r;
  assign in_p_clamped = (in_data.pen_pressure > PRESS_ONE) ? PRESS_ONE
                                                            : in_data.pen_pressure;
  assign out_free     = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_r   <= FOLLOW_RST;
      simulate_r <= 1'b0;
      min_dist_r <= MIN_DIST_RST;
      dist_lim_r <= DIST_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FOLLOW:     follow_r   <= cfg_wdata[FOLLOW_W-1:0];
        CFG_SIMULATE:   simulate_r <= cfg_wdata[0];
        CFG_MIN_DIST:   min_dist_r <= cfg_wdata;
        CFG_DIST_LIMIT: dist_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stroke control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stroke_r <= 1'b0;
      kept_x_r    <= '0;
      kept_y_r    <= '0;
      total_r     <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      fl_idx_r    <= '0;
    end else begin
      if (cmd.stroke_start) begin
        in_stroke_r <= 1'b1;
        total_r     <= '0;
        count_r     <= '0;
        ptr_r       <= '0;
      end else if (cmd.finish) begin
        in_stroke_r <= 1'b0;
        total_r     <= '0;
        count_r     <= '0;
      end else if (cmd.keep) begin
        kept_x_r <= cand_x_r;
        kept_y_r <= cand_y_r;
        if (count_r == CW'(WINDOW_SIZE)) begin
          total_r <= total_r + TW'(cand_p_r) - TW'(win_rd_r);
          ptr_r   <= (ptr_r == IW'(WINDOW_SIZE - 1)) ? '0 : ptr_r + 1'b1;
        end else begin
          total_r <= total_r + TW'(cand_p_r);
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.fl_clear) begin
        fl_idx_r <= '0;
      end else if (cmd.fl_inc) begin
        fl_idx_r <= fl_idx_r + 1'b1;
      end
    end
  end

  // Sample, candidate and distance registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      samp_x_r   <= in_data.pos_x;
      samp_y_r   <= in_data.pos_y;
      samp_p_r   <= in_p_clamped;
      samp_end_r <= in_data.stroke_end;
    end
    if (cmd.cand_raw) begin
      cand_x_r <= samp_x_r;
      cand_y_r <= samp_y_r;
      cand_p_r <= samp_p_r;
    end else if (cmd.cand_smooth) begin
      cand_x_r <= kept_x_r + dx_r[COORD_W-1:0];
      cand_y_r <= kept_y_r + dy_r[COORD_W-1:0];
      cand_p_r <= samp_p_r;
    end else if (cmd.press_half) begin
      cand_p_r <= PRESS_HALF;
    end else if (cmd.press_div) begin
      cand_p_r <= PRESS_ONE - quo;
    end
    if (cmd.diff) begin
      dx_r  <= rnd_x[DIFF_W+7:8];
      dy_r  <= rnd_y[DIFF_W+7:8];
      md2_r <= min_dist_r * min_dist_r;
    end
    if (cmd.square) begin
      sq_x_r <= sqr_x[2*COORD_W-1:0];
      sq_y_r <= sqr_y[2*COORD_W-1:0];
    end
    if (cmd.sum) begin
      d2_r <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
    end
  end

  // Pressure window and startup point buffer
  always_ff @(posedge clk) begin
    if (cmd.keep) begin
      if (count_r == CW'(WINDOW_SIZE)) begin
        win_mem[ptr_r] <= cand_p_r;
      end else begin
        win_mem[count_r[IW-1:0]] <= cand_p_r;
        pts_mem[count_r[IW-1:0]] <= {cand_x_r, cand_y_r};
      end
    end
    win_rd_r <= win_mem[ptr_r];
    pts_rd_r <= pts_mem[fl_idx_r];
  end

  // Iterative units; the divider is shared by the pressure and average steps
  pss_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (d2_r),
    .done     (root_done),
    .root     (root)
  );

  assign div_start = cmd.pdiv_start || cmd.avg_start;
  assign div_num   = cmd.pdiv_start ? {root[DIV_NUM_W-13:0], 12'b0}
                                    : DIV_NUM_W'(total_r) + DIV_NUM_W'(count_r >> 1);
  assign div_den   = cmd.pdiv_start ? lim_eff : DIV_DEN_W'(count_r);

  pss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.out_last <= cmd.out_last;
      unique case (cmd.out_sel)
        OUT_SEL_AVG: begin
          out_data_r.out_x        <= cand_x_r;
          out_data_r.out_y        <= cand_y_r;
          out_data_r.out_pressure <= quo;
        end
        OUT_SEL_RAW: begin
          out_data_r.out_x        <= cand_x_r;
          out_data_r.out_y        <= cand_y_r;
          out_data_r.out_pressure <= cand_p_r;
        end
        default: begin
          out_data_r.out_x        <= pts_rd_r[2*COORD_W-1:COORD_W];
          out_data_r.out_y        <= pts_rd_r[COORD_W-1:0];
          out_data_r.out_pressure <= quo;
        end
      endcase
    end
  end

  // Status
  always_comb begin
    sts.in_stroke     = in_stroke_r;
    sts.sample_end    = samp_end_r;
    sts.dist_keep     = d2_r >= D2_W'(md2_r);
    sts.simulate      = simulate_r;
    sts.half_hit      = {root, 1'b0} >= (ROOT_W + 1)'(lim_eff);
    sts.root_done     = root_done;
    sts.div_done      = div_done;
    sts.cnt_full      = count_r == CW'(WINDOW_SIZE);
    sts.cnt_fill_next = count_r == CW'(WINDOW_SIZE - 1);
    sts.fl_last       = (CW'(fl_idx_r) + 1'b1) == count_r;
    sts.out_free      = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window fill never runs past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_SIZE))
    else $error("kept count beyond window depth");

  // Running total stays within count full-scale pressures
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (TW + 13)'(total_r) <= (TW + 13)'(count_r) * (TW + 13)'(PRESS_ONE))
    else $error("window total out of range");

endmodule

// ===== src/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: steps one sample through distance check, optional pressure
// simulation, window update and result emission.
// ----------------------------------------------------------------------------
module pss_ctrl import pss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pss_sts_t sts,
  output pss_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_DIFF,
    S_SQ,
    S_SUM,
    S_CMP,
    S_SQRT_W,
    S_PCHK,
    S_PDIV_W,
    S_KEEP,
    S_AVG_S,
    S_AVG_W,
    S_EMIT_ONE,
    S_FL_RD,
    S_FL_EM,
    S_END_CHK,
    S_EMIT_RAW,
    S_FIN
  } state_t;

  state_t state_r;
  logic   end_phase_r;  // keeping the raw final sample
  logic   flush_r;      // pending result is a startup flush

  // State and phase flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_phase_r <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          end_phase_r <= 1'b0;
          if (in_valid) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!sts.in_stroke) begin
            state_r <= sts.sample_end ? S_EMIT_RAW : S_KEEP;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: state_r <= S_SQ;
        S_SQ:   state_r <= S_SUM;
        S_SUM:  state_r <= S_CMP;
        S_CMP: begin
          if (!sts.dist_keep)    state_r <= S_END_CHK;
          else if (sts.simulate) state_r <= S_SQRT_W;
          else                   state_r <= S_KEEP;
        end
        S_SQRT_W: if (sts.root_done) state_r <= S_PCHK;
        S_PCHK:   state_r <= sts.half_hit ? S_KEEP : S_PDIV_W;
        S_PDIV_W: if (sts.div_done) state_r <= S_KEEP;
        S_KEEP: begin
          if (sts.cnt_full) begin
            flush_r <= 1'b0;
            state_r <= S_AVG_S;
          end else if (end_phase_r || sts.cnt_fill_next) begin
            flush_r <= 1'b1;
            state_r <= S_AVG_S;
          end else begin
            state_r <= S_END_CHK;
          end
        end
        S_AVG_S: state_r <= S_AVG_W;
        S_AVG_W: if (sts.div_done) state_r <= flush_r ? S_FL_RD : S_EMIT_ONE;
        S_EMIT_ONE: begin
          if (sts.out_free) state_r <= end_phase_r ? S_FIN : S_END_CHK;
        end
        S_FL_RD: state_r <= S_FL_EM;
        S_FL_EM: begin
          if (sts.out_free) begin
            if (!sts.fl_last)     state_r <= S_FL_RD;
            else if (end_phase_r) state_r <= S_FIN;
            else                  state_r <= S_END_CHK;
          end
        end
        S_END_CHK: begin
          if (sts.sample_end && !end_phase_r) begin
            end_phase_r <= 1'b1;
            state_r     <= S_KEEP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT_RAW: if (sts.out_free) state_r <= S_IDLE;
        S_FIN:      state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.out_sel  = OUT_SEL_AVG;
    cmd.latch_in = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_DECIDE: begin
        cmd.cand_raw     = 1'b1;
        cmd.stroke_start = !sts.in_stroke && !sts.sample_end;
      end
      S_DIFF: cmd.diff = 1'b1;
      S_SQ:   cmd.square = 1'b1;
      S_SUM:  cmd.sum = 1'b1;
      S_CMP: begin
        cmd.cand_smooth = sts.dist_keep;
        cmd.sqrt_start  = sts.dist_keep && sts.simulate;
      end
      S_PCHK: begin
        cmd.press_half = sts.half_hit;
        cmd.pdiv_start = !sts.half_hit;
      end
      S_PDIV_W: cmd.press_div = sts.div_done;
      S_KEEP:   cmd.keep = 1'b1;
      S_AVG_S: begin
        cmd.avg_start = 1'b1;
        cmd.fl_clear  = 1'b1;
      end
      S_EMIT_ONE: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OUT_SEL_AVG;
        cmd.out_last = end_phase_r;
      end
      S_FL_EM: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OUT_SEL_FLUSH;
        cmd.out_last = end_phase_r && sts.fl_last;
        cmd.fl_inc   = sts.out_free;
      end
      S_END_CHK: cmd.cand_raw = sts.sample_end && !end_phase_r;
      S_EMIT_RAW: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OUT_SEL_RAW;
        cmd.out_last = 1'b1;
      end
      S_FIN: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  // Root result only arrives while it is awaited
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.root_done |-> state_r == S_SQRT_W)
    else $error("square root finished outside its wait state");

  // Divider result only arrives while it is awaited
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_PDIV_W || state_r == S_AVG_W))
    else $error("divider finished outside a wait state");

  // Never overwrite a result still held in the output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// ===== src/pen_stroke_point_smoother.sv =====
// ----------------------------------------------------------------------------
// pen_stroke_point_smoother
// Pen stroke point smoother: follows, thins and pressure-smooths pen samples.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------
//   in_      | input     | in_valid/in_stall  | in_item_t  (x, y, pressure, end)
//   out_     | output    | out_valid/out_stall| out_item_t (x, y, pressure, last)
//   cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One sample at a time. A kept sample takes the window update and, once the
// window fills or the stroke ends, an average divide; with simulated pressure
// it also takes a square root and may take a pressure divide. A startup flush
// emits up to WINDOW_SIZE items, each of which out_stall can hold.
// Reset is synchronous; no clearing pass is needed. The output register lets
// the last item of a sample wait while the next sample is taken.
// ----------------------------------------------------------------------------
module pen_stroke_point_smoother import pss_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  pss_cmd_t cmd;
  pss_sts_t sts;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pss_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
